// File: rtl/efb_pkg.sv
// Shared types, constants and helpers for the event fragment builder.
`default_nettype none

package efb_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int MAX_SOURCES_DEF = 64;

	localparam int NUM_W     = 32;
	localparam int SC_W      = 7;
	localparam int WIN_W     = 16;
	localparam int LIM_W     = 8;
	localparam int ENT_CNT_W = 9;   // per-entry fragment count, holds up to 511
	localparam int CNT_W     = 13;  // table-wide tallies, holds up to 8191
	localparam int OUT_CNT_W = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	localparam logic [SC_W-1:0]  SC_RESET    = SC_W'(1);
	localparam logic             PURGE_RESET = 1'b1;
	localparam logic [WIN_W-1:0] WIN_RESET   = WIN_W'(1000);
	localparam logic [LIM_W-1:0] LIM_RESET   = LIM_W'(200);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_COUNT,
		REG_PURGE_ENABLE,
		REG_AGE_WINDOW,
		REG_FORCE_LIMIT
	} reg_idx_t;

	// Pass that a token performs as it walks the chain.
	typedef enum logic [1:0] {
		OP_MATCH,
		OP_INSERT,
		OP_AGE,
		OP_FORCE
	} op_t;

	typedef struct packed {
		logic             valid;
		op_t              op;
		logic             hit;
		logic             placed;
		logic             done;
		logic             deliv;
		logic [NUM_W-1:0] last;
		logic [CNT_W-1:0] bcnt;
		logic [CNT_W-1:0] evict;
		logic [CNT_W-1:0] occ;
	} token_t;

	// Values broadcast to every cell.
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [SC_W-1:0]  source_count;
		logic             purge;
		logic [WIN_W-1:0] window;
		logic [NUM_W-1:0] last;
		logic             force_evict;
	} ctl_t;

	function automatic token_t mk_token(input op_t op, input logic hit);
		token_t t;
		t = '0;
		t.valid = 1'b1;
		t.op = op;
		t.hit = hit;
		return t;
	endfunction

	function automatic logic [OUT_CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
		logic [OUT_CNT_W-1:0] r;
		r = (v > CNT_W'((1 << OUT_CNT_W) - 1)) ? '1 : v[OUT_CNT_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/efb_cell.sv
// One table entry of the event fragment builder, with its token stage.
`default_nettype none

module efb_cell import efb_pkg::*; #(
	parameter int MAX_SOURCES = MAX_SOURCES_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire ctl_t   ctl,
	input  wire token_t tok_in,
	output token_t      tok_out
);

	logic                 v_q;
	logic [NUM_W-1:0]     num_q;
	logic [ENT_CNT_W-1:0] cnt_q;
	token_t               tok_q;

	logic                 nv;
	logic [NUM_W-1:0]     nn;
	logic [ENT_CNT_W-1:0] nc;
	token_t               t;

	always_comb begin
		nv = v_q;
		nn = num_q;
		nc = cnt_q;
		t  = tok_in;
		if (tok_in.valid) begin
			unique case (tok_in.op)
				OP_MATCH: begin
					if (v_q && num_q == ctl.num) begin
						t.hit = 1'b1;
						if (cnt_q < ENT_CNT_W'(MAX_SOURCES))
							nc = cnt_q + ENT_CNT_W'(1);
					end
				end
				OP_INSERT: begin
					if (!t.hit && !t.placed && !v_q) begin
						nv = 1'b1;
						nn = ctl.num;
						nc = ENT_CNT_W'(1);
						t.placed = 1'b1;
					end
					if (nv && nc == ENT_CNT_W'(ctl.source_count)) begin
						if (!t.done || nn > t.last)
							t.last = nn;
						t.done = 1'b1;
						if (nn != '0) begin
							t.deliv = 1'b1;
							t.bcnt = t.bcnt + CNT_W'(1);
						end
						nv = 1'b0;
					end
				end
				OP_AGE: begin
					if (ctl.purge && nv &&
					    ({1'b0, nn} + (NUM_W+1)'(ctl.window)) < {1'b0, ctl.last}) begin
						nv = 1'b0;
						t.evict = t.evict + CNT_W'(1);
					end
					if (nv)
						t.occ = t.occ + CNT_W'(1);
				end
				OP_FORCE: begin
					if (ctl.force_evict && nv && nn > NUM_W'(1)) begin
						nv = 1'b0;
						t.evict = t.evict + CNT_W'(1);
					end
					if (nv)
						t.occ = t.occ + CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= 1'b0;
			tok_q <= '0;
		end else begin
			v_q   <= nv;
			tok_q <= t;
		end
	end

	always_ff @(posedge clk) begin
		num_q <= nn;
		cnt_q <= nc;
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

// File: rtl/event_fragment_builder.sv
// Top level of the event fragment builder: control sequencer and the chain of entry cells.
`default_nettype none

// Fragment-counting event builder. Each accepted fragment transaction carries an event
// number; the open-event table lives in a row of TABLE_DEPTH cells, one entry per cell.
// A token walks the row four times per fragment, one cell per cycle: a match pass bumps
// the count of an open number, an insert pass opens a free entry and retires complete
// events, an age pass drops stale entries and counts the rest, and a force pass clears
// entries numbered above one from an overfull table. The result is ready once the token
// has made all four passes down the row; fragments are handled one at a time. The result
// sits in an output register, so the next fragment is taken while the previous result
// waits for result_ready. Configuration writes (cfg_we/cfg_index/cfg_data) must only
// happen while no fragment is in flight.
module event_fragment_builder import efb_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int MAX_SOURCES = MAX_SOURCES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// fragment channel
	input  wire logic                 fragment_valid,
	output logic                      fragment_ready,
	input  wire logic [NUM_W-1:0]     event_number,
	// result channel
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output logic                      event_done,
	output logic [NUM_W-1:0]          done_number,
	output logic                      delivered,
	output logic [NUM_W-1:0]          built_total,
	output logic [OUT_CNT_W-1:0]      aged_out,
	output logic [OUT_CNT_W-1:0]      forced_out,
	output logic [OUT_CNT_W-1:0]      occupancy,
	output logic                      table_overflow
);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_HOLD} state_t;

	// configuration registers
	logic [SC_W-1:0]  source_count_q;
	logic             purge_q;
	logic [WIN_W-1:0] window_q;
	logic [LIM_W-1:0] limit_q;

	state_t           state_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] last_q;
	logic             done_q;
	logic             deliv_q;
	logic             ovf_q;
	logic [CNT_W-1:0] aged_q;
	logic [CNT_W-1:0] forced_q;
	logic [CNT_W-1:0] occ_q;
	logic             force_q;
	logic [NUM_W-1:0] built_q;
	token_t           launch_q;

	ctl_t   ctl;
	token_t link [TABLE_DEPTH+1];
	token_t tail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_count_q <= SC_RESET;
			purge_q        <= PURGE_RESET;
			window_q       <= WIN_RESET;
			limit_q        <= LIM_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SOURCE_COUNT: source_count_q <= cfg_data[SC_W-1:0];
				REG_PURGE_ENABLE: purge_q        <= cfg_data[0];
				REG_AGE_WINDOW:   window_q       <= cfg_data[WIN_W-1:0];
				REG_FORCE_LIMIT:  limit_q        <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign ctl.num          = num_q;
	assign ctl.source_count = source_count_q;
	assign ctl.purge        = purge_q;
	assign ctl.window       = window_q;
	assign ctl.last         = last_q;
	assign ctl.force_evict  = force_q;

	// the cell row; the token enters at cell 0 and leaves after the last cell
	assign link[0] = launch_q;
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		efb_cell #(
			.MAX_SOURCES(MAX_SOURCES)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.tok_in (link[i]),
			.tok_out(link[i+1])
		);
	end
	assign tail = link[TABLE_DEPTH];

	assign fragment_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			num_q          <= '0;
			last_q         <= '0;
			done_q         <= 1'b0;
			deliv_q        <= 1'b0;
			ovf_q          <= 1'b0;
			aged_q         <= '0;
			forced_q       <= '0;
			occ_q          <= '0;
			force_q        <= 1'b0;
			built_q        <= '0;
			launch_q       <= '0;
			result_valid   <= 1'b0;
			event_done     <= 1'b0;
			done_number    <= '0;
			delivered      <= 1'b0;
			built_total    <= '0;
			aged_out       <= '0;
			forced_out     <= '0;
			occupancy      <= '0;
			table_overflow <= 1'b0;
		end else begin
			// in S_HOLD the load below decides result_valid
			if (result_valid && result_ready && state_q != S_HOLD)
				result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (fragment_valid) begin
						num_q    <= event_number;
						force_q  <= 1'b0;
						last_q   <= '0;
						launch_q <= mk_token(OP_MATCH, 1'b0);
						state_q  <= S_RUN;
					end else begin
						launch_q <= '0;
					end
				end
				S_RUN: begin
					if (tail.valid) begin
						unique case (tail.op)
							OP_MATCH: launch_q <= mk_token(OP_INSERT, tail.hit);
							OP_INSERT: begin
								done_q   <= tail.done;
								last_q   <= tail.done ? tail.last : '0;
								deliv_q  <= tail.deliv;
								ovf_q    <= !tail.hit && !tail.placed;
								built_q  <= built_q + NUM_W'(tail.bcnt);
								launch_q <= mk_token(OP_AGE, 1'b0);
							end
							OP_AGE: begin
								aged_q   <= tail.evict;
								force_q  <= purge_q && (tail.occ > CNT_W'(limit_q));
								launch_q <= mk_token(OP_FORCE, 1'b0);
							end
							OP_FORCE: begin
								forced_q <= tail.evict;
								occ_q    <= tail.occ;
								launch_q <= '0;
								state_q  <= S_HOLD;
							end
							default: launch_q <= '0;
						endcase
					end else begin
						launch_q <= '0;
					end
				end
				S_HOLD: begin
					launch_q <= '0;
					// wait for the output register to free up
					if (!result_valid || result_ready) begin
						result_valid   <= 1'b1;
						event_done     <= done_q;
						done_number    <= last_q;
						delivered      <= deliv_q;
						built_total    <= built_q;
						aged_out       <= sat_cnt(aged_q);
						forced_out     <= sat_cnt(forced_q);
						occupancy      <= sat_cnt(occ_q);
						table_overflow <= ovf_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					launch_q <= '0;
					state_q  <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_launch_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		fragment_valid && fragment_ready |=> launch_q.valid && launch_q.op == OP_MATCH)
		else $error("no match token launched after fragment transaction");

	a_tail_only_running: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> state_q == S_RUN)
		else $error("token left the cell row outside a running pass");

	a_delivered_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && delivered |-> event_done)
		else $error("delivered without a completed event");
`endif

endmodule

`default_nettype wire

// File: tb/sv/event_fragment_builder_tb.sv
// Self-checking testbench for the event fragment builder.
`timescale 1ns / 100ps

module event_fragment_builder_tb;
	import efb_pkg::*;

	localparam int DEPTH     = TABLE_DEPTH_DEF;
	localparam int SRC_MAX   = MAX_SOURCES_DEF;
	localparam int STALL_MAX = 20000;   // idle cycles before the watchdog fires

	// One result transaction as the block should present it.
	typedef struct {
		logic                 done;
		logic [NUM_W-1:0]     number;
		logic                 deliv;
		logic [NUM_W-1:0]     built;
		logic [OUT_CNT_W-1:0] aged;
		logic [OUT_CNT_W-1:0] forced;
		logic [OUT_CNT_W-1:0] occ;
		logic                 ovf;
	} build_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic fragment_valid;
	logic fragment_ready;
	logic [NUM_W-1:0] event_number;
	logic result_valid;
	logic result_ready;
	logic event_done;
	logic [NUM_W-1:0] done_number;
	logic delivered;
	logic [NUM_W-1:0] built_total;
	logic [OUT_CNT_W-1:0] aged_out;
	logic [OUT_CNT_W-1:0] forced_out;
	logic [OUT_CNT_W-1:0] occupancy;
	logic table_overflow;

	event_fragment_builder u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fragment_valid(fragment_valid), .fragment_ready(fragment_ready),
		.event_number(event_number),
		.result_valid(result_valid), .result_ready(result_ready),
		.event_done(event_done), .done_number(done_number), .delivered(delivered),
		.built_total(built_total), .aged_out(aged_out), .forced_out(forced_out),
		.occupancy(occupancy), .table_overflow(table_overflow)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Shadow of the block's configuration and open-event table.
	logic [SC_W-1:0]  sh_sources;
	logic             sh_purge;
	logic [WIN_W-1:0] sh_window;
	logic [LIM_W-1:0] sh_limit;
	logic             sh_valid [DEPTH];
	logic [NUM_W-1:0] sh_number [DEPTH];
	int               sh_count [DEPTH];
	logic [NUM_W-1:0] sh_built;

	logic [NUM_W-1:0] pending_numbers [$];   // fragments not yet offered
	build_result_t    expected_results [$];  // oldest first
	int               fail_count;
	bit               quiet;                 // 1 = no idling on either side

	function automatic logic [OUT_CNT_W-1:0] clip9(input int v);
		return (v > 511) ? 9'd511 : v[OUT_CNT_W-1:0];
	endfunction

	// Advance the shadow table by one fragment and return what the block should report.
	function automatic build_result_t build_step(input logic [NUM_W-1:0] num);
		build_result_t r;
		int hit, free_idx, aged, forced, occ;
		logic any_done, any_deliv;
		logic [NUM_W-1:0] last;
		hit = -1; free_idx = -1; aged = 0; forced = 0; occ = 0;
		any_done = 1'b0; any_deliv = 1'b0; last = '0;
		r.ovf = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			if (sh_valid[i]) begin
				if (sh_number[i] == num && hit < 0)
					hit = i;
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		if (hit >= 0) begin
			if (sh_count[hit] < SRC_MAX)
				sh_count[hit]++;
		end else if (free_idx >= 0) begin
			sh_valid[free_idx] = 1'b1;
			sh_number[free_idx] = num;
			sh_count[free_idx] = 1;
		end else begin
			r.ovf = 1'b1;
		end
		// completion checked on every entry at once
		for (int i = 0; i < DEPTH; i++) begin
			if (sh_valid[i] && sh_count[i] == int'(sh_sources)) begin
				if (!any_done || sh_number[i] > last)
					last = sh_number[i];
				any_done = 1'b1;
				if (sh_number[i] != '0) begin
					any_deliv = 1'b1;
					sh_built++;
				end
				sh_valid[i] = 1'b0;
			end
		end
		if (sh_purge) begin
			// age rule, compared without wrap
			for (int i = 0; i < DEPTH; i++) begin
				if (sh_valid[i] && ({1'b0, sh_number[i]} + sh_window) < {1'b0, last}) begin
					sh_valid[i] = 1'b0;
					aged++;
				end
			end
			for (int i = 0; i < DEPTH; i++)
				if (sh_valid[i])
					occ++;
			if (occ > int'(sh_limit)) begin
				for (int i = 0; i < DEPTH; i++) begin
					if (sh_valid[i] && sh_number[i] > 1) begin
						sh_valid[i] = 1'b0;
						forced++;
					end
				end
			end
		end
		occ = 0;
		for (int i = 0; i < DEPTH; i++)
			if (sh_valid[i])
				occ++;
		r.done = any_done;
		r.number = any_done ? last : '0;
		r.deliv = any_deliv;
		r.built = sh_built;
		r.aged = clip9(aged);
		r.forced = clip9(forced);
		r.occ = clip9(occ);
		return r;
	endfunction

	// Handshake flags seen at the last rising edge, used by the falling-edge drivers.
	bit frag_taken, res_taken;
	int gap_left, stall_left, idle_cycles;

	// Sender: offers queued fragments with a random gap after each one is taken.
	always @(negedge clk) begin
		logic nv;
		logic [NUM_W-1:0] nn;
		nv = fragment_valid;
		nn = event_number;
		if (arst_n) begin
			if (frag_taken)
				nv = 1'b0;
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_numbers.size() > 0) begin
					nn = pending_numbers.pop_front();
					nv = 1'b1;
					gap_left = quiet ? 0 : $urandom_range(0, 8);
				end
			end
		end
		fragment_valid <= nv;
		event_number <= nn;
	end

	// Receiver: random stall before each result that follows a taken one.
	always @(negedge clk) begin
		if (res_taken)
			stall_left = quiet ? 0 : $urandom_range(0, 8);
		if (stall_left > 0 && result_valid) begin
			stall_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// Monitor: predicts on fragment transactions, checks result transactions.
	always @(posedge clk) begin
		build_result_t e;
		frag_taken <= arst_n && fragment_valid && fragment_ready;
		res_taken <= arst_n && result_valid && result_ready;
		if (arst_n) begin
			if (fragment_valid && fragment_ready)
				expected_results = {expected_results, build_step(event_number)};
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					if (event_done !== e.done) begin
						$error("event_done exp %0d got %0d", e.done, event_done);
						fail_count++;
					end
					if (done_number !== e.number) begin
						$error("done_number exp %0h got %0h", e.number, done_number);
						fail_count++;
					end
					if (delivered !== e.deliv) begin
						$error("delivered exp %0d got %0d", e.deliv, delivered);
						fail_count++;
					end
					if (built_total !== e.built) begin
						$error("built_total exp %0d got %0d", e.built, built_total);
						fail_count++;
					end
					if (aged_out !== e.aged) begin
						$error("aged_out exp %0d got %0d", e.aged, aged_out);
						fail_count++;
					end
					if (forced_out !== e.forced) begin
						$error("forced_out exp %0d got %0d", e.forced, forced_out);
						fail_count++;
					end
					if (occupancy !== e.occ) begin
						$error("occupancy exp %0d got %0d", e.occ, occupancy);
						fail_count++;
					end
					if (table_overflow !== e.ovf) begin
						$error("table_overflow exp %0d got %0d", e.ovf, table_overflow);
						fail_count++;
					end
				end
			end
			// watchdog: a fragment's walk of the table stays far below the limit
			if ((fragment_valid && fragment_ready) || (result_valid && result_ready) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_MAX) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Wait for every queued fragment to be taken and every result to come back.
	task automatic drain();
		while (pending_numbers.size() > 0 || fragment_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write while idle; the shadow copy follows.
	task automatic set_reg(input reg_idx_t idx, input int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		case (idx)
			REG_SOURCE_COUNT: sh_sources = SC_W'(value);
			REG_PURGE_ENABLE: sh_purge = value[0];
			REG_AGE_WINDOW:   sh_window = WIN_W'(value);
			REG_FORCE_LIMIT:  sh_limit = LIM_W'(value);
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input int sc, input int pe, input int win, input int lim);
		drain();
		set_reg(REG_SOURCE_COUNT, sc);
		set_reg(REG_PURGE_ENABLE, pe);
		set_reg(REG_AGE_WINDOW, win);
		set_reg(REG_FORCE_LIMIT, lim);
	endtask

	task automatic send(input logic [NUM_W-1:0] num, input int times);
		repeat (times) pending_numbers = {pending_numbers, num};
	endtask

	initial begin
		logic [NUM_W-1:0] base;
		int sc, n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fragment_valid = 1'b0;
		event_number = '0;
		result_ready = 1'b0;
		frag_taken = 0; res_taken = 0;
		gap_left = 0; stall_left = 0; idle_cycles = 0;
		fail_count = 0;
		quiet = 0;
		sh_sources = SC_RESET;
		sh_purge = PURGE_RESET;
		sh_window = WIN_RESET;
		sh_limit = LIM_RESET;
		sh_built = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sh_valid[i] = 1'b0;
			sh_number[i] = '0;
			sh_count[i] = 0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: every fragment completes at once; event zero is not delivered.
		send(32'h0, 1);
		send(32'h1, 1);
		send(32'hFFFF_FFFF, 1);
		send(32'hAAAA_5555, 1);

		// Age rule with a zero window; event zero completing alone ages nothing.
		configure(2, 1, 0, 200);
		send(32'd3, 1);
		send(32'd0, 2);
		send(32'd2000, 2);
		send(32'hFFFF_FFFF, 1);

		// Overflow rule: entries 0 and 1 survive, larger ones go.
		configure(2, 1, 65535, 1);
		send(32'd0, 1);
		send(32'd1, 1);
		send(32'd7, 1);

		// Several completions after lowering source_count.
		configure(3, 0, 1000, 255);
		send(32'd40, 2);
		send(32'd90, 2);
		configure(2, 0, 1000, 255);
		send(32'd5, 1);

		// Count saturates; zero and out-of-range source counts never complete.
		configure(0, 0, 1000, 255);
		send(32'd77, 2);
		configure(127, 0, 1000, 255);
		send(32'd77, 66);
		configure(SRC_MAX, 0, 1000, 255);
		send(32'd77, 1);

		// Table full with purging off, then again with it on.
		configure(SRC_MAX, 0, 1000, 255);
		for (int i = 0; i < DEPTH + 2; i++)
			send(32'h1000_0000 + i * 32'h0101_0001, 1);
		quiet = 1;
		configure(SRC_MAX, 1, 1000, 255);
		send(32'h5555_AAAA, 2);
		configure(SRC_MAX, 1, 1000, 1);
		send(32'd9, 1);
		quiet = 0;

		// Random phases: mostly fragments of a small set of events, some noise.
		for (int ph = 0; ph < 13; ph++) begin
			quiet = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 3))
				0: sc = 1;
				1: sc = SRC_MAX;
				default: sc = $urandom_range(1, 4);
			endcase
			configure(sc, $urandom_range(0, 3) != 0,
				($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 40),
				($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 12));
			case ($urandom_range(0, 2))
				0: base = 32'h0;
				1: base = 32'hFFFF_FF00;
				default: base = $urandom;
			endcase
			n = (sc == SRC_MAX) ? 75 : 60;
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 9) == 0)
					send($urandom, 1);
				else
					send(base + $urandom_range(0, 60), 1);
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
rtl/efb_pkg.sv
rtl/efb_cell.sv
rtl/event_fragment_builder.sv
tb/sv/event_fragment_builder_tb.sv
